>>> rtl/hbond_energy_top_two_macros.svh
// Assertion macros shared by the hydrogen-bond energy engine.
`ifndef HBOND_ENERGY_TOP_TWO_MACROS_SVH
`define HBOND_ENERGY_TOP_TWO_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define HB_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HB_ASSERT_NXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> rtl/hbe_pkg.sv
// Shared types, codes and constants of the hydrogen-bond energy engine.
`default_nettype none
package hbe_pkg;
    localparam int MAX_RESIDUES = 1024;
    localparam int IDX_W = $clog2(MAX_RESIDUES);
    localparam logic [1:0] CMD_LOAD_C = 2'd0;
    localparam logic [1:0] CMD_EVAL_C = 2'd1;
    localparam logic [1:0] CMD_READ_C = 2'd2;
    localparam logic [1:0] REG_CUTOFF = 2'd0;
    localparam logic [1:0] REG_MIN = 2'd1;
    localparam logic [1:0] REG_FLOOR = 2'd2;
    localparam logic [1:0] REG_COUPLING = 2'd3;
    localparam logic [2:0] ATOM_N = 3'd0;
    localparam logic [2:0] ATOM_H = 3'd1;
    localparam logic [2:0] ATOM_CA = 3'd2;
    localparam logic [2:0] ATOM_C = 3'd3;
    localparam logic [2:0] ATOM_O = 3'd4;
    localparam int FIFO_DEPTH = 2;

    // One classified command, as passed from front to back.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [9:0]  ri;
        logic [9:0]  pi;
        logic [2:0]  sel;
        logic [19:0] x;
        logic [19:0] y;
        logic [19:0] z;
        logic        pro;
    } cmd_t;

    typedef struct packed {
        logic signed [17:0] energy;
        logic        in_range;
        logic [9:0]  a0i;
        logic signed [17:0] a0e;
        logic [9:0]  a1i;
        logic signed [17:0] a1e;
        logic [9:0]  d0i;
        logic signed [17:0] d0e;
        logic [9:0]  d1i;
        logic signed [17:0] d1e;
    } res_t;

    typedef struct packed {
        logic [9:0]  i0;
        logic signed [17:0] e0;
        logic [9:0]  i1;
        logic signed [17:0] e1;
    } slots_t;

    typedef struct packed {
        logic [15:0]        cutoff;
        logic [15:0]        min_dist;
        logic signed [17:0] floor_e;
        logic signed [17:0] coupling;
    } cfg_t;

    function automatic slots_t slot_insert(slots_t s, logic [9:0] p, logic signed [17:0] e);
        slots_t r;
        r = s;
        if (e < s.e0) begin
            r.i1 = s.i0;
            r.e1 = s.e0;
            r.i0 = p;
            r.e0 = e;
        end else if (e < s.e1) begin
            r.i1 = p;
            r.e1 = e;
        end
        return r;
    endfunction
endpackage
`default_nettype wire

>>> rtl/hbe_front.sv
// Input stage and command queue of the hydrogen-bond energy engine.
`default_nettype none
module hbe_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire hbe_pkg::cmd_t in_cmd,
    output logic               q_valid,
    input  wire logic          q_ready,
    output hbe_pkg::cmd_t      q_cmd
);
    localparam int PW = $clog2(hbe_pkg::FIFO_DEPTH);
    hbe_pkg::cmd_t mem_reg [hbe_pkg::FIFO_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;
    logic push, pop;

    assign s_tready = (cnt_reg != (PW+1)'(hbe_pkg::FIFO_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign push = s_tvalid && s_tready;
    assign pop  = q_valid && q_ready;
    assign q_cmd = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_cmd;
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

>>> rtl/hbe_divsqrt.sv
// Shared iterative square-root and divider unit, one bit per cycle.
`default_nettype none
module hbe_divsqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic        is_div,
    input  wire logic [63:0] a,
    input  wire logic [33:0] b,
    output logic             done,
    output logic [63:0]      q
);
    logic        busy_reg, div_reg;
    logic [6:0]  n_reg;
    logic [63:0] v_reg, r_reg, q_reg;
    logic [65:0] rem_reg;
    logic [33:0] b_reg;
    logic [65:0] rs;
    logic [65:0] trial;

    assign done = busy_reg && (n_reg == 7'd0);
    assign q = div_reg ? q_reg : r_reg;
    assign rs = {rem_reg[63:0], v_reg[63:62]};
    assign trial = {rem_reg[64:0], v_reg[63]};

    // Square root: two radicand bits per step; divide: one dividend bit per step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            div_reg <= is_div;
            n_reg <= is_div ? 7'd64 : 7'd32;
            v_reg <= a;
            b_reg <= b;
            r_reg <= '0;
            q_reg <= '0;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (n_reg == 7'd0) begin
                busy_reg <= 1'b0;
            end else begin
                n_reg <= n_reg - 7'd1;
                if (div_reg) begin
                    v_reg <= {v_reg[62:0], 1'b0};
                    if (trial >= {32'd0, b_reg}) begin
                        rem_reg <= trial - {32'd0, b_reg};
                        q_reg <= {q_reg[62:0], 1'b1};
                    end else begin
                        rem_reg <= trial;
                        q_reg <= {q_reg[62:0], 1'b0};
                    end
                end else begin
                    v_reg <= {v_reg[61:0], 2'b00};
                    if (rs >= {r_reg, 2'b01}) begin
                        rem_reg <= rs - {r_reg, 2'b01};
                        r_reg <= {r_reg[62:0], 1'b1};
                    end else begin
                        rem_reg <= rs;
                        r_reg <= {r_reg[62:0], 1'b0};
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/hbe_back.sv
// Execution stage: atom storage, energy sequencer and top-two slot update.
`default_nettype none
`include "hbond_energy_top_two_macros.svh"
module hbe_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire hbe_pkg::cfg_t cfg,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire hbe_pkg::cmd_t q_cmd,
    output logic               m_valid,
    input  wire logic          m_ready,
    output hbe_pkg::res_t      m_res
);
    localparam int RW = hbe_pkg::IDX_W;
    localparam int DEPTH = hbe_pkg::MAX_RESIDUES;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_RD    = 13'b0000000000010,
        S_CA    = 13'b0000000000100,
        S_RD2   = 13'b0000000001000,
        S_LAT   = 13'b0000000010000,
        S_D2    = 13'b0000000100000,
        S_SQ    = 13'b0000001000000,
        S_DIV   = 13'b0000010000000,
        S_SUM   = 13'b0000100000000,
        S_SLRD  = 13'b0001000000000,
        S_SLWR  = 13'b0010000000000,
        S_OUT   = 13'b0100000000000,
        S_CLR   = 13'b1000000000000
    } state_t;

    state_t state_reg;
    hbe_pkg::cmd_t cmd_reg;
    hbe_pkg::res_t res_reg;

    // Atom memories: one per atom kind, 60 bits of x,y,z.
    logic [59:0] mn [DEPTH];
    logic [59:0] mh [DEPTH];
    logic [59:0] mca [DEPTH];
    logic [59:0] mc [DEPTH];
    logic [59:0] mo [DEPTH];
    logic        mpro [DEPTH];
    logic [55:0] macc [DEPTH];
    logic [55:0] mdon [DEPTH];
    logic [RW-1:0] clr_reg;

    logic [59:0] n_rd, h_rd, ca_r_rd, ca_p_rd, c_rd, o_rd;
    logic        pro_rd;
    logic [55:0] acc_rd, don_rd;
    logic [59:0] pa_reg [4];
    logic [59:0] pb_reg [4];
    logic [1:0]  k_reg;
    logic [49:0] d2_reg [4];
    logic [63:0] dist_reg;
    logic signed [29:0] sum_reg;
    logic        close_reg;
    logic        ds_start, ds_div;
    logic        ds_done;
    logic [63:0] ds_q;
    logic        ds_wait_reg;
    logic [RW-1:0] r_a, p_a;
    logic signed [17:0] e_reg;
    hbe_pkg::slots_t sacc, sdon, nacc, ndon;
    logic [49:0] d2_c;
    logic [31:0] min2, cut2;
    logic [17:0] qmag;

    assign r_a = cmd_reg.ri[RW-1:0];
    assign p_a = cmd_reg.pi[RW-1:0];
    assign q_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_res = res_reg;
    assign min2 = 32'(cfg.min_dist) * 32'(cfg.min_dist);
    assign cut2 = 32'(cfg.cutoff) * 32'(cfg.cutoff);
    assign qmag = cfg.coupling[17] ? 18'(-cfg.coupling) : cfg.coupling;

    function automatic logic [49:0] dsq(logic [59:0] a, logic [59:0] b);
        logic signed [20:0] dx, dy, dz;
        dx = 21'(signed'(a[19:0])) - 21'(signed'(b[19:0]));
        dy = 21'(signed'(a[39:20])) - 21'(signed'(b[39:20]));
        dz = 21'(signed'(a[59:40])) - 21'(signed'(b[59:40]));
        return 50'(dx * dx) + 50'(dy * dy) + 50'(dz * dz);
    endfunction

    assign d2_c = dsq(pa_reg[k_reg], pb_reg[k_reg]);

    hbe_divsqrt u_ds (
        .aclk(aclk), .aresetn(aresetn), .start(ds_start), .is_div(ds_div),
        .a(ds_div ? {30'd0, qmag, 16'd0} : {d2_reg[k_reg][47:0], 16'd0}),
        .b(dist_reg[33:0]), .done(ds_done), .q(ds_q)
    );

    assign ds_start = ((state_reg == S_SQ) || (state_reg == S_DIV)) && !ds_wait_reg;
    assign ds_div = (state_reg == S_DIV);

    // Memory ports: atom writes on load, slot writes on clear and update, reads registered.
    always_ff @(posedge aclk) begin
        if (state_reg == S_RD && cmd_reg.cmd == hbe_pkg::CMD_LOAD_C) begin
            case (cmd_reg.sel)
                hbe_pkg::ATOM_N: begin
                    mn[r_a] <= {cmd_reg.z, cmd_reg.y, cmd_reg.x};
                    mpro[r_a] <= cmd_reg.pro;
                end
                hbe_pkg::ATOM_H: mh[r_a] <= {cmd_reg.z, cmd_reg.y, cmd_reg.x};
                hbe_pkg::ATOM_CA: mca[r_a] <= {cmd_reg.z, cmd_reg.y, cmd_reg.x};
                hbe_pkg::ATOM_C: mc[r_a] <= {cmd_reg.z, cmd_reg.y, cmd_reg.x};
                hbe_pkg::ATOM_O: mo[r_a] <= {cmd_reg.z, cmd_reg.y, cmd_reg.x};
                default: ;
            endcase
        end
        n_rd <= mn[r_a];
        h_rd <= mh[r_a];
        pro_rd <= mpro[r_a];
        ca_r_rd <= mca[r_a];
        ca_p_rd <= mca[p_a];
        c_rd <= mc[p_a];
        o_rd <= mo[p_a];
        acc_rd <= macc[r_a];
        don_rd <= mdon[(state_reg == S_SLRD) ? p_a : r_a];
        // After reset the slot memories are cleared one entry per cycle.
        if (state_reg == S_CLR) begin
            macc[clr_reg] <= '0;
            mdon[clr_reg] <= '0;
        end else if (state_reg == S_SLWR) begin
            macc[r_a] <= nacc;
            mdon[p_a] <= ndon;
        end
    end

    assign sacc = hbe_pkg::slots_t'(acc_rd);
    assign sdon = hbe_pkg::slots_t'(don_rd);
    assign nacc = hbe_pkg::slot_insert(sacc, cmd_reg.pi, e_reg);
    // A self pair touches both memories of one residue; they are separate, so order is free.
    assign ndon = hbe_pkg::slot_insert(sdon, cmd_reg.ri, e_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            ds_wait_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == RW'(DEPTH - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: if (q_valid) begin
                    cmd_reg <= q_cmd;
                    state_reg <= S_RD;
                end
                S_RD: begin
                    res_reg <= '0;
                    case (cmd_reg.cmd)
                        hbe_pkg::CMD_EVAL_C: state_reg <= S_CA;
                        hbe_pkg::CMD_READ_C: state_reg <= S_RD2;
                        default: state_reg <= S_OUT;
                    endcase
                end
                S_RD2: begin
                    res_reg.a0i <= acc_rd[55:46];
                    res_reg.a0e <= acc_rd[45:28];
                    res_reg.a1i <= acc_rd[27:18];
                    res_reg.a1e <= acc_rd[17:0];
                    res_reg.d0i <= don_rd[55:46];
                    res_reg.d0e <= don_rd[45:28];
                    res_reg.d1i <= don_rd[27:18];
                    res_reg.d1e <= don_rd[17:0];
                    state_reg <= S_OUT;
                end
                S_CA: begin
                    pa_reg[0] <= h_rd; pb_reg[0] <= o_rd;
                    pa_reg[1] <= h_rd; pb_reg[1] <= c_rd;
                    pa_reg[2] <= n_rd; pb_reg[2] <= c_rd;
                    pa_reg[3] <= n_rd; pb_reg[3] <= o_rd;
                    if (dsq(ca_r_rd, ca_p_rd) < 50'(cut2)) begin
                        res_reg.in_range <= 1'b1;
                        k_reg <= 2'd0;
                        close_reg <= 1'b0;
                        sum_reg <= '0;
                        state_reg <= pro_rd ? S_SUM : S_LAT;
                        e_reg <= '0;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_LAT: state_reg <= S_D2;
                S_D2: begin
                    d2_reg[k_reg] <= d2_c;
                    if (d2_c < 50'(min2) || d2_c == '0) close_reg <= 1'b1;
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd3) begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (close_reg) begin
                        state_reg <= S_SUM;
                    end else if (!ds_wait_reg) begin
                        ds_wait_reg <= 1'b1;
                    end else if (ds_done) begin
                        ds_wait_reg <= 1'b0;
                        dist_reg <= ds_q;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!ds_wait_reg) begin
                        ds_wait_reg <= 1'b1;
                    end else if (ds_done) begin
                        ds_wait_reg <= 1'b0;
                        // H-O and N-C add, H-C and N-O subtract; negative coupling swaps.
                        if (!k_reg[0] ^ cfg.coupling[17])
                            sum_reg <= sum_reg + 30'(ds_q[25:0]);
                        else
                            sum_reg <= sum_reg - 30'(ds_q[25:0]);
                        k_reg <= k_reg + 2'd1;
                        state_reg <= (k_reg == 2'd3) ? S_SUM : S_SQ;
                    end
                end
                S_SUM: begin
                    if (!pro_rd) begin
                        if (close_reg || sum_reg < 30'(cfg.floor_e))
                            e_reg <= cfg.floor_e;
                        else if (sum_reg > 30'sd131071)
                            e_reg <= 18'sd131071;
                        else
                            e_reg <= sum_reg[17:0];
                    end
                    state_reg <= S_SLRD;
                end
                S_SLRD: state_reg <= S_SLWR;
                S_SLWR: begin
                    res_reg.energy <= e_reg;
                    state_reg <= S_OUT;
                end
                S_OUT: if (m_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `HB_ASSERT_IMP(a_one_side, aclk, aresetn, m_valid, !q_ready)
    `HB_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_res))
    `HB_ASSERT_IMP(a_range, aclk, aresetn, m_valid && !res_reg.in_range, res_reg.energy == '0)
endmodule
`default_nettype wire

>>> rtl/hbond_energy_top_two.sv
// Top level of the hydrogen-bond energy engine.
// Commands enter a two-word queue, then run one at a time in the back end.
// A full evaluation runs four square roots and four divisions in turn on the shared
// one-bit-per-cycle root and divider unit. After reset the 1024 entries of the residue
// slot memories are cleared, during which no command leaves the queue; atoms and
// proline flags must be loaded before use.
`default_nettype none
module hbond_energy_top_two (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // command, residue_index, partner_index, atom_select, coord_x, coord_y, coord_z,
    // proline_flag
    input  wire logic [87:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // energy, in_range, best_acceptor_index, best_acceptor_energy, next_acceptor_index,
    // next_acceptor_energy, best_donor_index, best_donor_energy, next_donor_index,
    // next_donor_energy
    output logic [135:0]     m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [17:0] cfg_data
);
    hbe_pkg::cfg_t cfg_reg;
    hbe_pkg::cmd_t in_cmd, q_cmd;
    hbe_pkg::res_t res;
    logic q_valid, q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cutoff <= 16'd2304;
            cfg_reg.min_dist <= 16'd128;
            cfg_reg.floor_e <= -18'sd10138;
            cfg_reg.coupling <= -18'sd28557;
        end else if (cfg_we) begin
            case (cfg_index)
                hbe_pkg::REG_CUTOFF: cfg_reg.cutoff <= cfg_data[15:0];
                hbe_pkg::REG_MIN: cfg_reg.min_dist <= cfg_data[15:0];
                hbe_pkg::REG_FLOOR: cfg_reg.floor_e <= cfg_data;
                hbe_pkg::REG_COUPLING: cfg_reg.coupling <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_cmd.cmd = s_tdata[1:0];
    assign in_cmd.ri  = s_tdata[11:2];
    assign in_cmd.pi  = s_tdata[21:12];
    assign in_cmd.sel = s_tdata[24:22];
    assign in_cmd.x   = s_tdata[44:25];
    assign in_cmd.y   = s_tdata[64:45];
    assign in_cmd.z   = s_tdata[84:65];
    assign in_cmd.pro = s_tdata[85];

    hbe_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    hbe_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .q_valid(q_valid),
        .q_ready(q_ready), .q_cmd(q_cmd), .m_valid(m_tvalid), .m_ready(m_tready),
        .m_res(res)
    );

    assign m_tdata = {5'b0, res.d1e, res.d1i, res.d0e, res.d0i, res.a1e, res.a1i,
                      res.a0e, res.a0i, res.in_range, res.energy};
endmodule
`default_nettype wire
